// ===== design/bbm_pkg.sv =====
// Shared widths, operation codes, types and helpers for the blocked bitset membership table.
package bbm_pkg;

    localparam int FUNC_W = 3;
    localparam int ID_W   = 16;
    localparam int BIDX_W = 10;
    localparam int MASK_W = 64;
    localparam int CNT_W  = 17;
    localparam int POP_W  = 7;
    localparam int OFF_W  = 6;

    localparam int DEF_BLOCK_SIZE = 64;
    localparam int DEF_NUM_BLOCKS = 1024;

    typedef enum logic [FUNC_W-1:0] {
        FN_TEST   = 3'd0,
        FN_ADD    = 3'd1,
        FN_REMOVE = 3'd2,
        FN_AND    = 3'd3,
        FN_OR     = 3'd4,
        FN_ANDNOT = 3'd5,
        FN_CLEAR  = 3'd6,
        FN_READ   = 3'd7
    } t_func;

    // Where an entity id lands in the block memory.
    typedef struct packed {
        logic [ID_W-1:0]  blk;
        logic [OFF_W-1:0] off;
        logic             ok;
    } t_loc;

    // Population count of a 64-bit word as a balanced adder tree.
    function automatic logic [POP_W-1:0] f_pop64(input logic [MASK_W-1:0] v);
        logic [1:0] s1 [32];
        logic [2:0] s2 [16];
        logic [3:0] s3 [8];
        logic [4:0] s4 [4];
        logic [5:0] s5 [2];
        for (int i = 0; i < 32; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
        return {1'b0, s5[0]} + {1'b0, s5[1]};
    endfunction

endpackage

// ===== design/bbm_if.sv =====
// Valid/ready channel interfaces for the request and response words.
interface bbm_req_if;
    logic                       valid;
    logic                       ready;
    logic [bbm_pkg::FUNC_W-1:0] func;
    logic [bbm_pkg::ID_W-1:0]   entity_id;
    logic [bbm_pkg::BIDX_W-1:0] block_index;
    logic [bbm_pkg::MASK_W-1:0] block_mask;

    modport source (output valid, func, entity_id, block_index, block_mask, input ready);
    modport sink   (input valid, func, entity_id, block_index, block_mask, output ready);
endinterface

interface bbm_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       is_member;
    logic [bbm_pkg::CNT_W-1:0]  member_count;
    logic [bbm_pkg::MASK_W-1:0] block_bits;

    modport source (output valid, is_member, member_count, block_bits, input ready);
    modport sink   (input valid, is_member, member_count, block_bits, output ready);
endinterface

// ===== design/blocked_bitset_membership_table.sv =====
// Top level of the blocked bitset membership table with its running member count.
//
// The table keeps one bit per entity id in a block memory of NUM_BLOCKS words,
// each BLOCK_SIZE bits wide, beside a 17-bit count of set bits. Requests arrive
// on i_req (func, entity_id, block_index, block_mask) and each produces exactly
// one response word on o_rsp (is_member, member_count, block_bits).
// Every operation except clear is one read-modify-write of a single block:
// the request is taken in S_IDLE, the block is read in S_READ, modified
// and written back with both population counts registered in S_MOD, and the count is
// updated and the response loaded in S_DONE. An item therefore holds the block
// through these states in turn, since the memory read port and the popcount are
// registered, and no new request is taken until the block is back in S_IDLE.
// Clear all sweeps the memory one block a cycle and then passes through S_DONE.
// After reset the same sweep runs with i_req.ready low. The response sits in
// an output register: a new request is accepted while it waits, and if the
// receiver still stalls when the next response is ready, the block holds that
// response and stays busy until the register frees.
module blocked_bitset_membership_table #(
    parameter int BLOCK_SIZE = bbm_pkg::DEF_BLOCK_SIZE,
    parameter int NUM_BLOCKS = bbm_pkg::DEF_NUM_BLOCKS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bbm_req_if.sink   i_req,
    bbm_rsp_if.source o_rsp
);
    import bbm_pkg::*;

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MOD,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_clr_op;
    t_func                 r_func;
    logic [BIDX_W-1:0]     r_bidx;
    logic [BLOCK_SIZE-1:0] r_mask;
    logic [AW-1:0]         r_addr;
    logic                  r_ok;
    logic [OFF_W-1:0]      r_off;
    logic [CNT_W-1:0]      r_cnt;
    logic [POP_W-1:0]      r_pop_old;
    logic [POP_W-1:0]      r_pop_new;
    logic                  r_res_member;
    logic [BLOCK_SIZE-1:0] r_res_bits;
    logic                  r_out_valid;
    logic                  r_out_member;
    logic [CNT_W-1:0]      r_out_count;
    logic [MASK_W-1:0]     r_out_bits;

    t_loc                  w_loc;
    logic                  w_accept;
    logic                  w_ent_op;
    logic                  w_wr_op;
    logic [ID_W-1:0]       w_bidx_ext;
    logic                  w_bidx_ok;
    logic [BLOCK_SIZE-1:0] w_old;
    logic [BLOCK_SIZE-1:0] w_ebit;
    logic [BLOCK_SIZE-1:0] n_block;
    logic [CNT_W-1:0]      n_cnt;
    logic                  w_out_free;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [BLOCK_SIZE-1:0] w_wdata;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;

    assign w_accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    bbm_locate #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_locate (
        .i_clk       (i_clk),
        .i_load      (w_accept),
        .i_entity_id (i_req.entity_id),
        .o_loc       (w_loc)
    );

    // Block address and range check for the block-level operations.
    assign w_bidx_ext = ID_W'(r_bidx);
    assign w_bidx_ok  = ({1'b0, w_bidx_ext} < (ID_W+1)'(NUM_BLOCKS));

    assign w_ent_op = (r_func inside {FN_TEST, FN_ADD, FN_REMOVE});
    assign w_wr_op  = (r_func inside {FN_ADD, FN_REMOVE, FN_AND, FN_OR, FN_ANDNOT});

    // The read is issued in S_READ and its data is seen in S_MOD.
    assign w_re    = (r_state == S_READ);
    assign w_raddr = w_ent_op ? w_loc.blk[AW-1:0] : w_bidx_ext[AW-1:0];

    assign w_ebit = BLOCK_SIZE'(1) << r_off;

    always_comb begin
        case (r_func)
            FN_ADD:    n_block = w_old | w_ebit;
            FN_REMOVE: n_block = w_old & ~w_ebit;
            FN_AND:    n_block = w_old & r_mask;
            FN_OR:     n_block = w_old | r_mask;
            FN_ANDNOT: n_block = w_old & ~r_mask;
            default:   n_block = w_old;
        endcase
    end

    // The clear sweep and the write-back never overlap, so one write port serves both.
    assign w_we    = (r_state == S_CLEAR) || ((r_state == S_MOD) && w_wr_op && r_ok);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign w_wdata = (r_state == S_CLEAR) ? '0 : n_block;

    bbm_mem #(
        .WIDTH (BLOCK_SIZE),
        .DEPTH (NUM_BLOCKS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_old)
    );

    assign n_cnt      = r_cnt - CNT_W'(r_pop_old) + CNT_W'(r_pop_new);
    assign w_out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_op    <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A finished item refills the output register as the old word leaves.
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == AW'(NUM_BLOCKS - 1)) begin
                        r_clr_addr <= '0;
                        r_state    <= r_clr_op ? S_DONE : S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_func <= t_func'(i_req.func);
                        r_bidx <= i_req.block_index;
                        r_mask <= i_req.block_mask[BLOCK_SIZE-1:0];
                        if (t_func'(i_req.func) == FN_CLEAR) begin
                            // The count restarts at zero and the sweep wipes every block.
                            r_cnt        <= '0;
                            r_pop_old    <= '0;
                            r_pop_new    <= '0;
                            r_res_member <= 1'b0;
                            r_res_bits   <= '0;
                            r_clr_op     <= 1'b1;
                            r_clr_addr   <= '0;
                            r_state      <= S_CLEAR;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_addr  <= w_raddr;
                    r_off   <= w_loc.off;
                    r_ok    <= w_ent_op ? w_loc.ok : w_bidx_ok;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    // An out-of-range block leaves both counts equal and reads back as zero.
                    r_pop_old    <= f_pop64(MASK_W'(w_old));
                    r_pop_new    <= r_ok ? f_pop64(MASK_W'(n_block)) : f_pop64(MASK_W'(w_old));
                    r_res_member <= r_ok && (r_func == FN_TEST) && ((w_old & w_ebit) != '0);
                    r_res_bits   <= r_ok ? n_block : '0;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_cnt        <= n_cnt;
                        r_out_member <= r_res_member;
                        r_out_count  <= n_cnt;
                        r_out_bits   <= MASK_W'(r_res_bits);
                        r_clr_op     <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.is_member    = r_out_member;
    assign o_rsp.member_count = r_out_count;
    assign o_rsp.block_bits   = r_out_bits;

`ifndef SYNTHESIS
    // The memory is written only by the sweep or by the write-back step.
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || r_state == S_MOD))
        else $error("block memory written outside sweep or write-back");

    // A read is never issued while a write-back is pending, so no forwarding is needed.
    a_read_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_re |-> !w_we)
        else $error("block read overlaps a write");

    // Accepting clear all starts the sweep with the count at zero.
    a_clear_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.func == FN_CLEAR) |=> (r_state == S_CLEAR && r_cnt == '0))
        else $error("clear all did not start the sweep");

    // A new response word only ever comes from the completion step.
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !$past(o_rsp.valid)) |-> ($past(r_state) == S_DONE))
        else $error("response raised outside completion");

    // A completed word carries the updated running count.
    a_rsp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_DONE && r_state == S_IDLE) |-> (o_rsp.member_count == r_cnt))
        else $error("response count differs from the running count");
`endif

endmodule

// ===== design/bbm_mem.sv =====
// Simple dual-port block memory with a registered read port.
module bbm_mem #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bbm_locate.sv =====
// Splits an entity id into block number and bit offset by reciprocal multiplication.
module bbm_locate #(
    parameter int BLOCK_SIZE = 64,
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic [bbm_pkg::ID_W-1:0] i_entity_id,
    output bbm_pkg::t_loc            o_loc
);
    import bbm_pkg::*;

    // Exact quotient for every 16-bit id: q = (id * RECIP) >> SH.
    localparam int    LOG_B   = $clog2(BLOCK_SIZE);
    localparam int    SH      = ID_W + LOG_B;
    localparam longint RECIP  = ((longint'(1) << SH) + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int    RECIP_W = ID_W + 2;
    localparam int    PROD_W  = ID_W + RECIP_W;

    logic [ID_W-1:0]   r_eid;
    logic [PROD_W-1:0] r_prod;
    logic [ID_W-1:0]   w_quo;
    logic [ID_W-1:0]   w_rem;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_eid  <= i_entity_id;
            r_prod <= PROD_W'(i_entity_id) * PROD_W'(RECIP_W'(RECIP));
        end
    end

    assign w_quo = ID_W'(r_prod >> SH);
    assign w_rem = r_eid - ID_W'(w_quo * ID_W'(BLOCK_SIZE));

    assign o_loc.blk = w_quo;
    assign o_loc.off = w_rem[OFF_W-1:0];
    assign o_loc.ok  = ({1'b0, w_quo} < (ID_W+1)'(NUM_BLOCKS));

endmodule
